@@ rtl/core/dlf_pkg.sv @@
package dlf_pkg;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 5;

  // one inference never emits more than this many results
  localparam int RESULT_LIMIT = 16;
  localparam int NEURON_W     = 4;

  // item queue between front and back end, power of two
  localparam int QUEUE_DEPTH = 4;

  // parameter defaults
  localparam int DEF_MAX_INPUTS  = 16;
  localparam int DEF_MAX_NEURONS = 16;
  localparam int DEF_DATA_WIDTH  = 16;

  // register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_IN_COUNT  = 2'd0,
    REG_OUT_COUNT = 2'd1,
    REG_ACT_MODE  = 2'd2
  } reg_idx_t;

  // queued operation
  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // live configuration
  typedef struct packed {
    logic [CFG_DW-1:0] in_count;
    logic [CFG_DW-1:0] out_count;
    logic              act_mode;
  } cfg_t;

  // back end status toward the front end
  typedef struct packed {
    logic pop;
    logic running;
  } eng_status_t;

endpackage

@@ rtl/core/dlf_front.sv @@
module dlf_front import dlf_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_NEURONS = DEF_MAX_NEURONS,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [7:0]            in_weight_index,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  eng_status_t           status,
  output logic                  q_valid,
  output op_t                   q_op,
  output logic [7:0]            q_widx,
  output logic [DATA_WIDTH-1:0] q_value
);

  localparam int DEPTH = MAX_INPUTS * MAX_NEURONS;
  localparam int QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

  op_t                   op_q    [QUEUE_DEPTH];
  logic [7:0]            widx_q  [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] value_q [QUEUE_DEPTH];

  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           accept, drop, push, pop;
  op_t            op_in;

  // classify the beat: weight writes outside the store are dropped here
  always_comb begin
    op_in  = in_kind ? OP_SAMPLE : OP_WEIGHT;
    drop   = (op_in == OP_WEIGHT) && (32'(in_weight_index) >= DEPTH);
    busy   = (count_r == QCW'(QUEUE_DEPTH));
    accept = start && !busy;
    push   = accept && !drop;
    pop    = status.pop;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r]    <= op_in;
      widx_q[wr_ptr_r]  <= in_weight_index;
      value_q[wr_ptr_r] <= in_value;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPW'(1);
      priority case ({push, pop})
        2'b10:   count_r <= count_r + QCW'(1);
        2'b01:   count_r <= count_r - QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // head of queue
  assign q_valid = (count_r != '0);
  assign q_op    = op_q[rd_ptr_r];
  assign q_widx  = widx_q[rd_ptr_r];
  assign q_value = value_q[rd_ptr_r];

endmodule

@@ rtl/core/dlf_engine.sv @@
module dlf_engine import dlf_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_NEURONS = DEF_MAX_NEURONS,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  op_t                   q_op,
  input  logic [7:0]            q_widx,
  input  logic [DATA_WIDTH-1:0] q_value,
  output eng_status_t           status,
  output logic                  out_strobe,
  output logic [NEURON_W-1:0]   out_neuron,
  output logic [DATA_WIDTH-1:0] out_activation,
  output logic                  out_last
);

  localparam int DEPTH = MAX_INPUTS * MAX_NEURONS;
  localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NIW   = $clog2(MAX_INPUTS + 1);
  localparam int AW    = $clog2(DEPTH + RESULT_LIMIT * MAX_INPUTS);
  localparam int NLIM  = (MAX_NEURONS < RESULT_LIMIT) ? MAX_NEURONS : RESULT_LIMIT;
  localparam int PW    = 2 * DATA_WIDTH;
  localparam int ACCW  = PW + SIW + 1;
  localparam int HIW   = ACCW - DATA_WIDTH + 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                state_r;
  logic [NIW-1:0]        recv_r;
  logic [NEURON_W-1:0]   i_r;
  logic [SIW-1:0]        j_r;
  logic [AW-1:0]         base_r;

  logic [NIW-1:0]        n_in, pos;
  logic [CFG_DW-1:0]     n_out;
  logic                  pop, wr_weight, wr_sample, complete;
  logic                  issue, j_last, i_last;
  logic [AW-1:0]         addr;

  logic [DATA_WIDTH-1:0] wmem [DEPTH];
  logic [DATA_WIDTH-1:0] smem [MAX_INPUTS];

  logic signed [DATA_WIDTH-1:0] w_rd_r, s_rd_r;
  logic                  s1_v_r, s1_ok_r, s1_first_r, s1_lastj_r, s1_lastn_r;
  logic [NEURON_W-1:0]   s1_nrn_r;
  logic signed [PW-1:0]  prod_r;
  logic                  s2_v_r, s2_first_r, s2_lastj_r, s2_lastn_r;
  logic [NEURON_W-1:0]   s2_nrn_r;
  logic signed [ACCW-1:0] acc_r;
  logic                  s3_done_r, s3_lastn_r;
  logic [NEURON_W-1:0]   s3_nrn_r;

  logic signed [ACCW-1:0] shifted;
  logic [HIW-1:0]        hi_bits;
  logic [DATA_WIDTH-1:0] sat, act;

  logic                  out_strobe_r, out_last_r;
  logic [NEURON_W-1:0]   out_neuron_r;
  logic [DATA_WIDTH-1:0] out_activation_r;

  // effective counts
  always_comb begin
    if (cfg.in_count == '0)                 n_in = NIW'(1);
    else if (32'(cfg.in_count) > MAX_INPUTS) n_in = NIW'(MAX_INPUTS);
    else                                     n_in = NIW'(cfg.in_count);
    if (cfg.out_count == '0)                n_out = CFG_DW'(1);
    else if (32'(cfg.out_count) > NLIM)      n_out = CFG_DW'(NLIM);
    else                                     n_out = cfg.out_count;
  end

  // dispatch of the queue head
  always_comb begin
    pop       = (state_r == ST_IDLE) && q_valid;
    wr_weight = pop && (q_op == OP_WEIGHT);
    wr_sample = pop && (q_op == OP_SAMPLE);
    pos       = (recv_r >= n_in) ? (n_in - NIW'(1)) : recv_r;
    complete  = (NIW'(pos + NIW'(1)) == n_in);
    issue     = (state_r == ST_RUN);
    addr      = base_r + AW'(j_r);
    j_last    = (NIW'(NIW'(j_r) + NIW'(1)) == n_in);
    i_last    = (CFG_DW'(CFG_DW'(i_r) + CFG_DW'(1)) == n_out);
  end

  assign status.pop     = pop;
  assign status.running = issue;

  // sequencer: sample count, neuron and input counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      recv_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      base_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (wr_sample) begin
            if (complete) begin
              recv_r  <= '0;
              i_r     <= '0;
              j_r     <= '0;
              base_r  <= '0;
              state_r <= ST_RUN;
            end else begin
              recv_r <= NIW'(pos + NIW'(1));
            end
          end
        end
        ST_RUN: begin
          if (j_last) begin
            j_r    <= '0;
            base_r <= base_r + AW'(n_in);
            i_r    <= i_r + NEURON_W'(1);
            if (i_last) state_r <= ST_IDLE;
          end else begin
            j_r <= j_r + SIW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // weight store
  always_ff @(posedge clk) begin
    if (wr_weight) wmem[WAW'(q_widx)] <= q_value;
    w_rd_r <= wmem[addr[WAW-1:0]];
  end

  // sample buffer
  always_ff @(posedge clk) begin
    if (wr_sample) smem[SIW'(pos)] <= q_value;
    s_rd_r <= smem[j_r];
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_done_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_v_r       <= issue;
      s2_v_r       <= s1_v_r;
      s3_done_r    <= s2_v_r && s2_lastj_r;
      out_strobe_r <= s3_done_r;
    end
  end

  // read stage tags
  always_ff @(posedge clk) begin
    s1_ok_r    <= (addr < AW'(DEPTH));
    s1_first_r <= (j_r == '0);
    s1_lastj_r <= j_last;
    s1_lastn_r <= i_last;
    s1_nrn_r   <= i_r;
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (s1_ok_r) prod_r <= w_rd_r * s_rd_r;
    else         prod_r <= '0;
    s2_first_r <= s1_first_r;
    s2_lastj_r <= s1_lastj_r;
    s2_lastn_r <= s1_lastn_r;
    s2_nrn_r   <= s1_nrn_r;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= (s2_first_r ? '0 : acc_r) + {{(ACCW-PW){prod_r[PW-1]}}, prod_r};
    end
    s3_lastn_r <= s2_lastn_r;
    s3_nrn_r   <= s2_nrn_r;
  end

  // scale down by 8 bits, saturate, activation
  always_comb begin
    shifted = acc_r >>> 8;
    hi_bits = shifted[ACCW-1:DATA_WIDTH-1];
    if ((&hi_bits) || !(|hi_bits)) sat = shifted[DATA_WIDTH-1:0];
    else if (shifted[ACCW-1])      sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    else                           sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    act = (cfg.act_mode && sat[DATA_WIDTH-1]) ? '0 : sat;
  end

  // result register
  always_ff @(posedge clk) begin
    if (s3_done_r) begin
      out_activation_r <= act;
      out_neuron_r     <= s3_nrn_r;
      out_last_r       <= s3_lastn_r;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_neuron     = out_neuron_r;
  assign out_activation = out_activation_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/core/dense_layer_forward.sv @@
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+---------------------------
// input    | in_kind, in_weight_index, in_value            | start high, busy low
// result   | out_neuron, out_activation, out_last          | out_strobe, one cycle
// config   | cfg_index, cfg_wdata                          | cfg_we, no wait
//
// a weight beat or a non-final sample beat is stored as the back end takes it;
// the beat that completes an inference is dispatched and then holds the back end
// while it forms every weight-sample product of the layer, one product per cycle
// through the shared multiply-accumulate unit; each result then passes the read,
// multiply, accumulate and result registers after the last product of its neuron.
// a four-entry item queue absorbs beats while the back end runs; busy is high
// when it is full. synchronous active-low reset clears control state only,
// the weight store and sample buffer need no clearing. the result side cannot stall.
module dense_layer_forward import dlf_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_NEURONS = DEF_MAX_NEURONS,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [7:0]            in_weight_index,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_strobe,
  output logic [NEURON_W-1:0]   out_neuron,
  output logic [DATA_WIDTH-1:0] out_activation,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_wdata
);

  cfg_t                  cfg_r;
  eng_status_t           status;
  logic                  q_valid;
  op_t                   q_op;
  logic [7:0]            q_widx;
  logic [DATA_WIDTH-1:0] q_value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_count  <= CFG_DW'(16);
      cfg_r.out_count <= CFG_DW'(16);
      cfg_r.act_mode  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_COUNT:  cfg_r.in_count  <= cfg_wdata;
        REG_OUT_COUNT: cfg_r.out_count <= cfg_wdata;
        REG_ACT_MODE:  cfg_r.act_mode  <= cfg_wdata[0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  // front end and item queue
  dlf_front #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_NEURONS (MAX_NEURONS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_weight_index (in_weight_index),
    .in_value        (in_value),
    .status          (status),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_widx          (q_widx),
    .q_value         (q_value)
  );

  // back end: stores and multiply-accumulate pipeline
  dlf_engine #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_NEURONS (MAX_NEURONS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_widx         (q_widx),
    .q_value        (q_value),
    .status         (status),
    .out_strobe     (out_strobe),
    .out_neuron     (out_neuron),
    .out_activation (out_activation),
    .out_last       (out_last)
  );

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    status.pop |-> q_valid)
    else $error("pop from empty item queue");

  // no dispatch while a dot product run is in progress
  a_run_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    status.running |-> !status.pop)
    else $error("queue pop during compute run");

  // relu results are never negative
  a_relu_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && cfg_r.act_mode) |-> !out_activation[DATA_WIDTH-1])
    else $error("negative result with relu active");

  // once the queue is full, busy stays high until the back end pops an item
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !status.pop) |=> busy)
    else $error("busy dropped without a pop");

endmodule

@@ test/tb.sv @@
module tb import dlf_pkg::*; ();

  localparam int SETTLE_CYCLES = 32;
  localparam int RAND_BEATS    = 85;
  localparam int STORE_DEPTH   = DEF_MAX_INPUTS * DEF_MAX_NEURONS;

  // one neuron output as it leaves the block
  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic [15:0]         activation;
    logic                last;
  } neuron_out_t;

  // layer predictor plus the queue of neuron outputs still owed by the block
  class neuron_scoreboard;
    logic [15:0]       weights [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    logic [15:0]       samples [DEF_MAX_INPUTS];
    int                seen;
    logic [CFG_DW-1:0] in_count_r;
    logic [CFG_DW-1:0] out_count_r;
    logic              relu_r;
    neuron_out_t       owed_q[$];
    int                errors;

    function new();
      seen        = 0;
      in_count_r  = 5'd16;
      out_count_r = 5'd16;
      relu_r      = 1'b1;
      errors      = 0;
      foreach (written[a]) written[a] = 1'b0;
    endfunction

    // zero acts as one, anything above the given maximum is clipped to it
    function int clamp_count(logic [CFG_DW-1:0] v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int n_in();
      return clamp_count(in_count_r, DEF_MAX_INPUTS);
    endfunction

    function int n_out();
      return clamp_count(out_count_r, DEF_MAX_NEURONS);
    endfunction

    // weight addresses touched by one inference at the current counts
    function int span();
      return n_in() * n_out();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    function void set_reg(reg_idx_t idx, logic [CFG_DW-1:0] d);
      case (idx)
        REG_IN_COUNT:  in_count_r = d;
        REG_OUT_COUNT: out_count_r = d;
        REG_ACT_MODE:  relu_r = d[0];
        default: ;
      endcase
    endfunction

    // accepted input beat: store it, and on the closing sample predict the layer
    function void take_beat(op_t kind, logic [7:0] idx, logic [15:0] v);
      int          ni, no, pos, i, j;
      longint      acc, y;
      neuron_out_t r;
      if (kind == OP_WEIGHT) begin
        weights[idx] = v;
        written[idx] = 1'b1;
        return;
      end
      ni = n_in();
      no = n_out();
      pos = (seen > ni - 1) ? ni - 1 : seen;
      samples[pos] = v;
      seen = pos + 1;
      if (seen < ni) return;
      seen = 0;
      for (i = 0; i < no; i++) begin
        acc = 0;
        for (j = 0; j < ni; j++)
          acc += longint'($signed(samples[j])) * longint'($signed(weights[i * ni + j]));
        // floor shift back to q8.8, then saturate and activate
        y = acc >>> 8;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        if (relu_r && y < 0) y = 0;
        r.neuron     = NEURON_W'(i);
        r.activation = 16'(y);
        r.last       = (i == no - 1);
        owed_q.push_back(r);
      end
    endfunction

    task check_neuron(logic [NEURON_W-1:0] neuron, logic [15:0] act, logic last);
      neuron_out_t w;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result neuron %0d act %h", neuron, act));
        return;
      end
      w = owed_q.pop_front();
      if (neuron !== w.neuron)
        report($sformatf("neuron got %0d want %0d", neuron, w.neuron));
      if (act !== w.activation)
        report($sformatf("neuron %0d activation got %h want %h", w.neuron, act, w.activation));
      if (last !== w.last)
        report($sformatf("neuron %0d last got %b want %b", w.neuron, last, w.last));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_kind;
  logic [7:0]          in_weight_index;
  logic [15:0]         in_value;
  logic                out_strobe;
  logic [NEURON_W-1:0] out_neuron;
  logic [15:0]         out_activation;
  logic                out_last;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;

  neuron_scoreboard sb;
  bit               steady;
  int               rand_beats;

  dense_layer_forward u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_weight_index (in_weight_index),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_neuron      (out_neuron),
    .out_activation  (out_activation),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  always #5 clk = ~clk;

  // result side, one beat per strobe
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_strobe)) sb.report("result strobe unknown");
      else if (out_strobe) sb.check_neuron(out_neuron, out_activation, out_last);
    end
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // q8.8 values biased toward extremes and small magnitudes
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3, 4, 5: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input beat, sometimes preceded by an idle gap with start low, but not in a steady stretch
  task automatic send_beat(input op_t kind, input logic [7:0] idx, input logic [15:0] v);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 16) gap = 1;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start           <= 1'b1;
    in_kind         <= kind;
    in_weight_index <= idx;
    in_value        <= v;
    do @(posedge clk); while (busy);
    sb.take_beat(kind, idx, v);
  endtask

  // drop start, let every owed result arrive, then let the queue settle
  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  // mask bit 0 in_count, bit 1 out_count, bit 2 act_mode
  task automatic set_config(input logic [CFG_DW-1:0] ic, input logic [CFG_DW-1:0] oc,
                            input logic [CFG_DW-1:0] act, input logic [2:0] mask);
    if (mask[0]) cfg_write(REG_IN_COUNT, ic);
    if (mask[1]) cfg_write(REG_OUT_COUNT, oc);
    if (mask[2]) cfg_write(REG_ACT_MODE, act);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // write every weight the current counts read that was never written
  task automatic fill_weights();
    int a, n;
    n = sb.span();
    for (a = 0; a < n; a++)
      if (!sb.written[a]) send_beat(OP_WEIGHT, 8'(a), rand_value());
  endtask

  initial begin
    int       i, phase_len, span;
    logic [4:0] ic, oc;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = OP_SAMPLE;
    in_weight_index = '0;
    in_value        = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_IN_COUNT;
    cfg_wdata       = '0;
    steady          = 1'b0;
    rand_beats      = 0;
    sb              = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one neuron over all sixteen samples, relu from reset
    set_config(5'd16, 5'd1, 5'd0, 3'b011);
    fill_weights();
    for (i = 0; i < 16; i++) send_beat(OP_SAMPLE, 8'($urandom), rand_value());
    wait_drain();

    // one sample fanned out to all sixteen neurons
    set_config(5'd1, 5'd16, 5'd0, 3'b011);
    fill_weights();
    send_beat(OP_SAMPLE, 8'($urandom), rand_value());
    wait_drain();

    // 2 x 2 layer: both saturation limits, floor on a tiny negative sum
    set_config(5'd2, 5'd2, 5'd0, 3'b111);
    send_beat(OP_WEIGHT, 8'd0, 16'h8000);
    send_beat(OP_WEIGHT, 8'd1, 16'h8000);
    send_beat(OP_WEIGHT, 8'd2, 16'h7FFF);
    send_beat(OP_WEIGHT, 8'd3, 16'h0001);
    send_beat(OP_WEIGHT, 8'd255, 16'hFFFF);
    send_beat(OP_SAMPLE, 8'd0, 16'h8000);
    send_beat(OP_SAMPLE, 8'd255, 16'h8000);
    send_beat(OP_SAMPLE, 8'd0, 16'h0000);
    send_beat(OP_SAMPLE, 8'd0, 16'hFFFF);
    wait_drain();

    // same data under relu
    set_config(5'd0, 5'd0, 5'd1, 3'b100);
    send_beat(OP_SAMPLE, 8'd0, 16'h8000);
    send_beat(OP_SAMPLE, 8'd0, 16'h8000);
    wait_drain();

    // a zero in_count acts as one, oversize out_count clips to all neurons
    set_config(5'd0, 5'd31, 5'd0, 3'b011);
    fill_weights();
    send_beat(OP_SAMPLE, 8'd0, 16'h7FFF);
    wait_drain();

    // in_count lowered partway through an inference lets the next sample complete it
    set_config(5'd8, 5'd2, 5'd0, 3'b011);
    fill_weights();
    for (i = 0; i < 5; i++) send_beat(OP_SAMPLE, 8'($urandom), rand_value());
    wait_drain();
    set_config(5'd3, 5'd0, 5'd0, 3'b001);
    send_beat(OP_SAMPLE, 8'($urandom), rand_value());
    wait_drain();

    // random phases: new settings, then a mix of samples and weight rewrites
    while (rand_beats < RAND_BEATS) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       ic = 5'd0;
          1:       ic = 5'd1;
          2:       ic = 5'd16;
          default: ic = 5'd31;
        endcase
        // a wide input side goes with a single neuron to keep the store small
        if (ic >= 5'd16) begin
          oc = 5'($urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 3))
            0:       oc = 5'd0;
            1:       oc = 5'd1;
            2:       oc = 5'd16;
            default: oc = 5'd31;
          endcase
        end
      end else begin
        ic = 5'($urandom_range(1, 6));
        oc = 5'($urandom_range(1, 6));
      end
      set_config(ic, oc, 5'($urandom), 3'($urandom_range(1, 7)));
      fill_weights();
      span = sb.span();
      phase_len = $urandom_range(4, 30);
      repeat (phase_len) begin
        steady = (rand_beats >= 30 && rand_beats < 70);
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 9) < 7)
            send_beat(OP_WEIGHT, 8'($urandom_range(0, span - 1)), rand_value());
          else
            send_beat(OP_WEIGHT, 8'($urandom), rand_value());
        end else begin
          send_beat(OP_SAMPLE, 8'($urandom), rand_value());
        end
        rand_beats++;
      end
      steady = 1'b0;
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dlf_pkg.sv
rtl/core/dlf_front.sv
rtl/core/dlf_engine.sv
rtl/core/dense_layer_forward.sv
test/tb.sv
